// ===== design/nsr_pkg.sv =====
// ----------------------------------------------------------------------------
// nsr_pkg
// Shared types, codes and region tables for the nine-slice rectangle generator.
// ----------------------------------------------------------------------------
package nsr_pkg;

	localparam int LEN_BITS       = 15;
	localparam int NUM_REGIONS    = 9;
	localparam int REGION_BITS    = 4;
	localparam int CFG_INDEX_BITS = 3;
	localparam int QUEUE_DEPTH    = 2;
	localparam int QUEUE_AW       = 1;

	typedef logic [LEN_BITS-1:0]    len_t;
	typedef logic [NUM_REGIONS-1:0] region_mask_t;

	typedef enum logic [REGION_BITS-1:0] {
		REGION_TOP_LEFT     = 4'd0,
		REGION_TOP          = 4'd1,
		REGION_TOP_RIGHT    = 4'd2,
		REGION_LEFT         = 4'd3,
		REGION_CENTRE       = 4'd4,
		REGION_RIGHT        = 4'd5,
		REGION_BOTTOM_LEFT  = 4'd6,
		REGION_BOTTOM       = 4'd7,
		REGION_BOTTOM_RIGHT = 4'd8,
		REGION_WHOLE        = 4'd9
	} region_t;

	// slice position along one axis
	typedef enum logic [1:0] {
		KIND_LEAD  = 2'b00,
		KIND_MID   = 2'b01,
		KIND_TRAIL = 2'b10
	} kind_t;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_SRC_X         = 3'd0,
		CFG_SRC_Y         = 3'd1,
		CFG_SRC_WIDTH     = 3'd2,
		CFG_SRC_HEIGHT    = 3'd3,
		CFG_BORDER_LEFT   = 3'd4,
		CFG_BORDER_TOP    = 3'd5,
		CFG_BORDER_RIGHT  = 3'd6,
		CFG_BORDER_BOTTOM = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		len_t src_width;
		len_t src_height;
		len_t border_left;
		len_t border_top;
		len_t border_right;
		len_t border_bottom;
	} cfg_len_t;

	typedef struct packed {
		region_t region;
		logic    last;
		logic    whole;
	} tag_t;

	function automatic region_mask_t want_mask(logic l, logic t, logic r, logic b);
		region_mask_t m;
		m = '0;
		m[REGION_TOP_LEFT]     = l & t;
		m[REGION_TOP]          = t;
		m[REGION_TOP_RIGHT]    = r & t;
		m[REGION_LEFT]         = l;
		m[REGION_CENTRE]       = 1'b1;
		m[REGION_RIGHT]        = r;
		m[REGION_BOTTOM_LEFT]  = l & b;
		m[REGION_BOTTOM]       = b;
		m[REGION_BOTTOM_RIGHT] = r & b;
		return m;
	endfunction

	function automatic region_t first_region(region_mask_t m);
		region_t rg;
		rg = REGION_CENTRE;
		for (int i = NUM_REGIONS - 1; i >= 0; i--) begin
			if (m[i]) rg = region_t'(REGION_BITS'(i));
		end
		return rg;
	endfunction

	function automatic kind_t x_kind(region_t rg);
		kind_t k;
		unique case (rg) inside
			REGION_TOP_LEFT, REGION_LEFT, REGION_BOTTOM_LEFT:    k = KIND_LEAD;
			REGION_TOP_RIGHT, REGION_RIGHT, REGION_BOTTOM_RIGHT: k = KIND_TRAIL;
			default:                                             k = KIND_MID;
		endcase
		return k;
	endfunction

	function automatic kind_t y_kind(region_t rg);
		kind_t k;
		unique case (rg) inside
			REGION_TOP_LEFT, REGION_TOP, REGION_TOP_RIGHT:             k = KIND_LEAD;
			REGION_BOTTOM_LEFT, REGION_BOTTOM, REGION_BOTTOM_RIGHT:    k = KIND_TRAIL;
			default:                                                   k = KIND_MID;
		endcase
		return k;
	endfunction

	// trailing slices that also need length > leading border
	function automatic logic x_lead_chk(region_t rg);
		logic c;
		unique case (rg) inside
			REGION_TOP_RIGHT, REGION_BOTTOM_RIGHT: c = 1'b1;
			default:                               c = 1'b0;
		endcase
		return c;
	endfunction

	function automatic logic y_lead_chk(region_t rg);
		logic c;
		unique case (rg) inside
			REGION_BOTTOM_LEFT, REGION_BOTTOM, REGION_BOTTOM_RIGHT: c = 1'b1;
			default:                                                c = 1'b0;
		endcase
		return c;
	endfunction

endpackage

// ===== design/nsr_front.sv =====
// ----------------------------------------------------------------------------
// nsr_front
// Config registers, input word accept and region classification into queue.
// ----------------------------------------------------------------------------
module nsr_front #(
	parameter int COORD_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [nsr_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [((COORD_BITS > nsr_pkg::LEN_BITS) ? COORD_BITS : nsr_pkg::LEN_BITS)-1:0]
	                                            cfg_wdata,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [COORD_BITS-1:0]        dest_x,
	input  logic signed [COORD_BITS-1:0]        dest_y,
	input  nsr_pkg::len_t                       dest_width,
	input  nsr_pkg::len_t                       dest_height,
	input  logic                                q_full,
	output logic                                q_push,
	output logic [2*COORD_BITS+2*nsr_pkg::LEN_BITS+nsr_pkg::NUM_REGIONS:0] q_item,
	output logic signed [COORD_BITS-1:0]        src_x,
	output logic signed [COORD_BITS-1:0]        src_y,
	output nsr_pkg::cfg_len_t                   cfg_len
);

	logic signed [COORD_BITS-1:0] src_x_q;
	logic signed [COORD_BITS-1:0] src_y_q;
	nsr_pkg::cfg_len_t            cfg_len_q;
	nsr_pkg::region_mask_t        mask;
	logic                         whole;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_x_q   <= '0;
			src_y_q   <= '0;
			cfg_len_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (nsr_pkg::cfg_reg_t'(cfg_index))
				nsr_pkg::CFG_SRC_X:         src_x_q <= cfg_wdata[COORD_BITS-1:0];
				nsr_pkg::CFG_SRC_Y:         src_y_q <= cfg_wdata[COORD_BITS-1:0];
				nsr_pkg::CFG_SRC_WIDTH:     cfg_len_q.src_width <= cfg_wdata[nsr_pkg::LEN_BITS-1:0];
				nsr_pkg::CFG_SRC_HEIGHT:    cfg_len_q.src_height <= cfg_wdata[nsr_pkg::LEN_BITS-1:0];
				nsr_pkg::CFG_BORDER_LEFT:   cfg_len_q.border_left <= cfg_wdata[nsr_pkg::LEN_BITS-1:0];
				nsr_pkg::CFG_BORDER_TOP:    cfg_len_q.border_top <= cfg_wdata[nsr_pkg::LEN_BITS-1:0];
				nsr_pkg::CFG_BORDER_RIGHT:  cfg_len_q.border_right <= cfg_wdata[nsr_pkg::LEN_BITS-1:0];
				nsr_pkg::CFG_BORDER_BOTTOM: cfg_len_q.border_bottom <= cfg_wdata[nsr_pkg::LEN_BITS-1:0];
			endcase
		end
	end

	always_comb begin
		mask = nsr_pkg::want_mask(|cfg_len_q.border_left, |cfg_len_q.border_top,
			|cfg_len_q.border_right, |cfg_len_q.border_bottom);
		// no borders at all: one word maps whole dest onto whole source
		whole = ~(|{cfg_len_q.border_left, cfg_len_q.border_top,
			cfg_len_q.border_right, cfg_len_q.border_bottom});
	end

	assign in_stall = q_full;
	assign q_push   = in_valid & ~q_full;
	assign q_item   = {whole, mask, dest_height, dest_width, dest_y, dest_x};
	assign src_x    = src_x_q;
	assign src_y    = src_y_q;
	assign cfg_len  = cfg_len_q;

endmodule

// ===== design/nsr_fifo.sv =====
// ----------------------------------------------------------------------------
// nsr_fifo
// Short queue between the classifier front and the region back end.
// ----------------------------------------------------------------------------
module nsr_fifo #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	output logic         full,
	input  logic         pop,
	output logic         empty,
	output logic [W-1:0] head
);

	logic [W-1:0]                entry_q [nsr_pkg::QUEUE_DEPTH];
	logic [nsr_pkg::QUEUE_AW-1:0] wr_ptr_q;
	logic [nsr_pkg::QUEUE_AW-1:0] rd_ptr_q;
	logic [nsr_pkg::QUEUE_AW:0]   count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign full  = (count_q == (nsr_pkg::QUEUE_AW+1)'(nsr_pkg::QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = entry_q[rd_ptr_q];

endmodule

// ===== design/nsr_axis.sv =====
// ----------------------------------------------------------------------------
// nsr_axis
// One axis of a slice: two pipe stages giving clipped dest and fitted source.
// ----------------------------------------------------------------------------
module nsr_axis #(
	parameter int COORD_BITS = 16
) (
	input  logic                         clk,
	input  logic                         en,
	input  nsr_pkg::kind_t               kind,
	input  logic                         lead_chk,
	input  logic                         centre,
	input  logic signed [COORD_BITS-1:0] pos,
	input  nsr_pkg::len_t                len,
	input  logic signed [COORD_BITS-1:0] spos,
	input  nsr_pkg::len_t                slen,
	input  nsr_pkg::len_t                a,
	input  nsr_pkg::len_t                c,
	output logic                         ok,
	output logic [COORD_BITS-1:0]        dp,
	output nsr_pkg::len_t                dl,
	output logic [COORD_BITS-1:0]        sp,
	output nsr_pkg::len_t                sl
);

	localparam int LB = nsr_pkg::LEN_BITS;
	localparam int LW = LB + 2;
	localparam int SW = ((COORD_BITS > 16) ? COORD_BITS : 16) + 2;

	function automatic logic [COORD_BITS-1:0] sat_coord(logic signed [SW-1:0] v);
		logic in_range;
		in_range = (&v[SW-1:COORD_BITS-1]) | ~(|v[SW-1:COORD_BITS-1]);
		if (in_range) return v[COORD_BITS-1:0];
		else if (v[SW-1]) return {1'b1, {(COORD_BITS-1){1'b0}}};
		else return {1'b0, {(COORD_BITS-1){1'b1}}};
	endfunction

	logic signed [LW-1:0] len_l, a_l, c_l, slen_l, mid_l, smid_l, dl_calc;
	logic signed [SW-1:0] pos_w, spos_w, len_w, slen_w, a_w, dbase, sbase;
	logic                 lead_rej;

	logic signed [LW-1:0] dl_s1, smid_s1;
	logic signed [SW-1:0] dbase_s1, sbase_s1;
	logic                 lead_rej_s1, mid_s1, trail_s1, centre_s1;

	logic signed [SW-1:0] dl_w, dp_raw, sp_raw;
	logic                 ok_calc;
	nsr_pkg::len_t        sl_calc;

	logic                 ok_s2;
	logic [COORD_BITS-1:0] dp_s2, sp_s2;
	nsr_pkg::len_t        dl_s2, sl_s2;

	// stage 1: slice length on the dest side and base coordinates
	always_comb begin
		len_l  = {{(LW-LB){1'b0}}, len};
		a_l    = {{(LW-LB){1'b0}}, a};
		c_l    = {{(LW-LB){1'b0}}, c};
		slen_l = {{(LW-LB){1'b0}}, slen};
		mid_l  = len_l - a_l - c_l;
		smid_l = slen_l - a_l - c_l;
		pos_w  = {{(SW-COORD_BITS){pos[COORD_BITS-1]}}, pos};
		spos_w = {{(SW-COORD_BITS){spos[COORD_BITS-1]}}, spos};
		len_w  = {{(SW-LB){1'b0}}, len};
		slen_w = {{(SW-LB){1'b0}}, slen};
		a_w    = {{(SW-LB){1'b0}}, a};
		lead_rej = lead_chk & (len <= a);
		case (kind)
			nsr_pkg::KIND_LEAD: begin
				dl_calc = (len <= a) ? len_l : a_l;
				dbase   = pos_w;
				sbase   = spos_w;
			end
			nsr_pkg::KIND_TRAIL: begin
				// anchored at far edge: start = end - clipped length
				dl_calc = (len <= c) ? len_l : c_l;
				dbase   = pos_w + len_w;
				sbase   = spos_w + slen_w;
			end
			default: begin
				dl_calc = mid_l;
				dbase   = pos_w + a_w;
				sbase   = spos_w + a_w;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dl_s1       <= dl_calc;
			smid_s1     <= smid_l;
			dbase_s1    <= dbase;
			sbase_s1    <= sbase;
			lead_rej_s1 <= lead_rej;
			mid_s1      <= (kind == nsr_pkg::KIND_MID);
			trail_s1    <= (kind == nsr_pkg::KIND_TRAIL);
			centre_s1   <= centre;
		end
	end

	// stage 2: final positions, saturation and reject
	always_comb begin
		dl_w    = {{(SW-LW){dl_s1[LW-1]}}, dl_s1};
		dp_raw  = trail_s1 ? (dbase_s1 - dl_w) : dbase_s1;
		sp_raw  = trail_s1 ? (sbase_s1 - dl_w) : sbase_s1;
		ok_calc = ~lead_rej_s1 & ~dl_s1[LW-1] & (|dl_s1) &
			(~mid_s1 | centre_s1 | (~smid_s1[LW-1] & (|smid_s1)));
		if (mid_s1) sl_calc = smid_s1[LW-1] ? '0 : smid_s1[LB-1:0];
		else        sl_calc = dl_s1[LB-1:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ok_s2 <= ok_calc;
			dp_s2 <= sat_coord(dp_raw);
			sp_s2 <= sat_coord(sp_raw);
			dl_s2 <= dl_s1[LB-1:0];
			sl_s2 <= sl_calc;
		end
	end

	assign ok = ok_s2;
	assign dp = dp_s2;
	assign dl = dl_s2;
	assign sp = sp_s2;
	assign sl = sl_s2;

endmodule

// ===== design/nsr_back.sv =====
// ----------------------------------------------------------------------------
// nsr_back
// Region sequencer and result pipe: one region word per cycle from queue head unless out_stall holds the pipe.
// ----------------------------------------------------------------------------
module nsr_back #(
	parameter int COORD_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [2*COORD_BITS+2*nsr_pkg::LEN_BITS+nsr_pkg::NUM_REGIONS:0] q_head,
	input  logic                         q_empty,
	output logic                         q_pop,
	input  logic signed [COORD_BITS-1:0] src_x,
	input  logic signed [COORD_BITS-1:0] src_y,
	input  nsr_pkg::cfg_len_t            cfg_len,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [nsr_pkg::REGION_BITS-1:0] region,
	output logic                         drawn,
	output logic signed [COORD_BITS-1:0] out_dest_x,
	output logic signed [COORD_BITS-1:0] out_dest_y,
	output nsr_pkg::len_t                out_dest_width,
	output nsr_pkg::len_t                out_dest_height,
	output logic signed [COORD_BITS-1:0] out_src_x,
	output logic signed [COORD_BITS-1:0] out_src_y,
	output nsr_pkg::len_t                out_src_width,
	output nsr_pkg::len_t                out_src_height,
	output logic                         last
);

	localparam int LB      = nsr_pkg::LEN_BITS;
	localparam int OFS_W   = 2*COORD_BITS;
	localparam int OFS_H   = OFS_W + LB;
	localparam int OFS_M   = OFS_H + LB;
	localparam int OFS_WH  = OFS_M + nsr_pkg::NUM_REGIONS;

	logic signed [COORD_BITS-1:0] hd_x, hd_y;
	nsr_pkg::len_t                hd_w, hd_h;
	nsr_pkg::region_mask_t        hd_mask;
	logic                         hd_whole;

	logic                  started_q;
	nsr_pkg::region_mask_t rem_q;

	nsr_pkg::region_mask_t cur_mask, pick_bit, rem_next;
	nsr_pkg::region_t      pick;
	nsr_pkg::tag_t         tag_sel, tag_s1, tag_s2;
	logic                  en, issue, vld_s1, vld_s2;

	logic                  ok_x, ok_y, show;
	logic [COORD_BITS-1:0] dp_x, dp_y, sp_x, sp_y;
	nsr_pkg::len_t         dl_x, dl_y, sl_x, sl_y;

	always_comb begin
		hd_x     = q_head[COORD_BITS-1:0];
		hd_y     = q_head[OFS_W-1:COORD_BITS];
		hd_w     = q_head[OFS_H-1:OFS_W];
		hd_h     = q_head[OFS_M-1:OFS_H];
		hd_mask  = q_head[OFS_WH-1:OFS_M];
		hd_whole = q_head[OFS_WH];

		cur_mask = started_q ? rem_q : hd_mask;
		pick     = nsr_pkg::first_region(cur_mask);
		pick_bit = nsr_pkg::region_mask_t'(1) << pick;
		rem_next = cur_mask & ~pick_bit;

		// whole image rides the centre path with all borders zero
		tag_sel.region = hd_whole ? nsr_pkg::REGION_WHOLE : pick;
		tag_sel.last   = (rem_next == '0);
		tag_sel.whole  = hd_whole;
	end

	assign en    = ~vld_s2 | ~out_stall;
	assign issue = en & ~q_empty;
	assign q_pop = issue & tag_sel.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			rem_q     <= '0;
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
		end else if (en) begin
			vld_s1 <= issue;
			vld_s2 <= vld_s1;
			if (issue) begin
				started_q <= ~tag_sel.last;
				rem_q     <= rem_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s1 <= tag_sel;
			tag_s2 <= tag_s1;
		end
	end

	nsr_axis #(.COORD_BITS(COORD_BITS)) u_axis_x (
		.clk      (clk),
		.en       (en),
		.kind     (nsr_pkg::x_kind(pick)),
		.lead_chk (nsr_pkg::x_lead_chk(pick)),
		.centre   (pick == nsr_pkg::REGION_CENTRE),
		.pos      (hd_x),
		.len      (hd_w),
		.spos     (src_x),
		.slen     (cfg_len.src_width),
		.a        (cfg_len.border_left),
		.c        (cfg_len.border_right),
		.ok       (ok_x),
		.dp       (dp_x),
		.dl       (dl_x),
		.sp       (sp_x),
		.sl       (sl_x)
	);

	nsr_axis #(.COORD_BITS(COORD_BITS)) u_axis_y (
		.clk      (clk),
		.en       (en),
		.kind     (nsr_pkg::y_kind(pick)),
		.lead_chk (nsr_pkg::y_lead_chk(pick)),
		.centre   (pick == nsr_pkg::REGION_CENTRE),
		.pos      (hd_y),
		.len      (hd_h),
		.spos     (src_y),
		.slen     (cfg_len.src_height),
		.a        (cfg_len.border_top),
		.c        (cfg_len.border_bottom),
		.ok       (ok_y),
		.dp       (dp_y),
		.dl       (dl_y),
		.sp       (sp_y),
		.sl       (sl_y)
	);

	// rejected slices report zero rectangles
	assign show            = tag_s2.whole | (ok_x & ok_y);
	assign out_valid       = vld_s2;
	assign region          = tag_s2.region;
	assign last            = tag_s2.last;
	assign drawn           = show;
	assign out_dest_x      = show ? dp_x : '0;
	assign out_dest_y      = show ? dp_y : '0;
	assign out_dest_width  = show ? dl_x : '0;
	assign out_dest_height = show ? dl_y : '0;
	assign out_src_x       = show ? sp_x : '0;
	assign out_src_y       = show ? sp_y : '0;
	assign out_src_width   = show ? sl_x : '0;
	assign out_src_height  = show ? sl_y : '0;

endmodule

// ===== design/nine_slice_rect_generator.sv =====
// ----------------------------------------------------------------------------
// nine_slice_rect_generator
// Nine-patch draw rectangle generator: one dest rectangle in, up to nine
// region words out (or one whole-image word when all borders are zero).
//
//   channel | handshake              | payload
//   --------+------------------------+--------------------------------------
//   cfg     | cfg_wr_en              | cfg_index, cfg_wdata
//   in      | in_valid / in_stall    | dest_x, dest_y, dest_width, dest_height
//   out     | out_valid / out_stall  | region, drawn, out_dest_*, out_src_*, last
//
// Each input word gives 1 to 9 result words at one per clock unless out_stall
// holds the pipe, set by the region sequencer in the back end.
// A 2-entry queue sits between input and sequencer, so in_stall rises only
// when the queue is full. out_stall freezes the two back-end compute stages.
// Reset clears all config registers to zero and empties queue and pipe.
// ----------------------------------------------------------------------------
module nine_slice_rect_generator #(
	parameter int COORD_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [nsr_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [((COORD_BITS > nsr_pkg::LEN_BITS) ? COORD_BITS : nsr_pkg::LEN_BITS)-1:0]
	                                            cfg_wdata,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [COORD_BITS-1:0]        dest_x,
	input  logic signed [COORD_BITS-1:0]        dest_y,
	input  nsr_pkg::len_t                       dest_width,
	input  nsr_pkg::len_t                       dest_height,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [nsr_pkg::REGION_BITS-1:0]     region,
	output logic                                drawn,
	output logic signed [COORD_BITS-1:0]        out_dest_x,
	output logic signed [COORD_BITS-1:0]        out_dest_y,
	output nsr_pkg::len_t                       out_dest_width,
	output nsr_pkg::len_t                       out_dest_height,
	output logic signed [COORD_BITS-1:0]        out_src_x,
	output logic signed [COORD_BITS-1:0]        out_src_y,
	output nsr_pkg::len_t                       out_src_width,
	output nsr_pkg::len_t                       out_src_height,
	output logic                                last
);

	localparam int ITEM_W = 2*COORD_BITS + 2*nsr_pkg::LEN_BITS + nsr_pkg::NUM_REGIONS + 1;

	logic                         q_full, q_push, q_empty, q_pop;
	logic [ITEM_W-1:0]            q_item, q_head;
	logic signed [COORD_BITS-1:0] src_x, src_y;
	nsr_pkg::cfg_len_t            cfg_len;

	nsr_front #(.COORD_BITS(COORD_BITS)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.dest_x      (dest_x),
		.dest_y      (dest_y),
		.dest_width  (dest_width),
		.dest_height (dest_height),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_item      (q_item),
		.src_x       (src_x),
		.src_y       (src_y),
		.cfg_len     (cfg_len)
	);

	nsr_fifo #(.W(ITEM_W)) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_item),
		.full      (q_full),
		.pop       (q_pop),
		.empty     (q_empty),
		.head      (q_head)
	);

	nsr_back #(.COORD_BITS(COORD_BITS)) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_head          (q_head),
		.q_empty         (q_empty),
		.q_pop           (q_pop),
		.src_x           (src_x),
		.src_y           (src_y),
		.cfg_len         (cfg_len),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.region          (region),
		.drawn           (drawn),
		.out_dest_x      (out_dest_x),
		.out_dest_y      (out_dest_y),
		.out_dest_width  (out_dest_width),
		.out_dest_height (out_dest_height),
		.out_src_x       (out_src_x),
		.out_src_y       (out_src_y),
		.out_src_width   (out_src_width),
		.out_src_height  (out_src_height),
		.last            (last)
	);

endmodule
